// ----- hw/rtl/sfd_pkg.sv -----
// Shared types and constants of the servo frame decoder.
// Used by sfd_front, sfd_queue, sfd_back and sbus_frame_decoder; no dependencies.
`default_nettype none

package sfd_pkg;

    localparam int CH_BITS = 11;
    localparam int MAX_OUT = 16;
    localparam int FLAG_BITS = 4;

    // floor(x / 11) == (x * 373) >> 12 for every x up to 352
    localparam logic [8:0] CH_DIV_MUL = 9'd373;
    localparam int CH_DIV_SHIFT = 12;

    // configuration register indexes
    localparam logic [1:0] REG_SKIP_HEADER  = 2'd0;
    localparam logic [1:0] REG_SKIP_FOOTER  = 2'd1;
    localparam logic [1:0] REG_HEADER_VALUE = 2'd2;
    localparam logic [1:0] REG_FOOTER_VALUE = 2'd3;

    // result status codes
    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // one finished frame, passed from the front to the back
    typedef struct packed {
        logic                                bad;
        logic [FLAG_BITS-1:0]                flags;
        logic [MAX_OUT-1:0][CH_BITS-1:0]     value;
    } sfd_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfd_front.sv -----
// Front end: configuration registers, byte classification, bit unpacking and channel store.
// Depends on sfd_pkg; emits one sfd_cmd_t per marked byte.
`default_nettype none

module sfd_front #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_in,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_frame,
    input  wire logic                  wr_en,
    input  wire logic [1:0]            wr_index,
    input  wire logic [7:0]            wr_data,
    output logic                       cmd_valid,
    output sfd_pkg::sfd_cmd_t          cmd
);

    localparam int DATA_BYTES = (NUM_CHANNELS * sfd_pkg::CH_BITS + 7) / 8;
    localparam int POS_SAT = DATA_BYTES + 4;
    localparam int POS_W = $clog2(POS_SAT + 1);
    localparam int CH_W = $clog2(NUM_CHANNELS + 1);
    localparam int ADDR_W = $clog2(NUM_CHANNELS);
    localparam int OUT_CH = (NUM_CHANNELS < sfd_pkg::MAX_OUT) ? NUM_CHANNELS
                                                              : sfd_pkg::MAX_OUT;
    localparam int DIV_W = POS_W + 3;
    localparam int PROD_W = DIV_W + 9;

    logic                          skip_header_reg;
    logic                          skip_footer_reg;
    logic [7:0]                    header_value_reg;
    logic [7:0]                    footer_value_reg;

    logic [17:0]                   bit_buffer_reg, bit_buffer_next;
    logic [4:0]                    bit_count_reg, bit_count_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          bad_reg, bad_next;
    logic [3:0]                    flags_reg, flags_next;

    logic [sfd_pkg::CH_BITS-1:0]   store_reg [NUM_CHANNELS];
    logic                          store_we;
    logic [ADDR_W-1:0]             store_addr;

    logic                          hdr;
    logic [POS_W-1:0]              chan_pos;
    logic [POS_W-1:0]              chan_pos_inc;
    logic [POS_W-1:0]              expected;
    logic [22:0]                   shifted;
    logic [17:0]                   buf_or;
    logic [4:0]                    cnt_sum;
    logic [DIV_W-1:0]              bits_done;
    logic [PROD_W-1:0]             div_prod;
    logic [CH_W-1:0]               ch_num;
    logic [sfd_pkg::MAX_OUT-1:0][sfd_pkg::CH_BITS-1:0] snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_header_reg  <= 1'b0;
            skip_footer_reg  <= 1'b0;
            header_value_reg <= 8'h0F;
            footer_value_reg <= 8'h00;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                sfd_pkg::REG_SKIP_HEADER:  skip_header_reg  <= wr_data[0];
                sfd_pkg::REG_SKIP_FOOTER:  skip_footer_reg  <= wr_data[0];
                sfd_pkg::REG_HEADER_VALUE: header_value_reg <= wr_data;
                sfd_pkg::REG_FOOTER_VALUE: footer_value_reg <= wr_data;
            endcase
        end
    end

    assign hdr          = !skip_header_reg;
    assign chan_pos     = pos_reg - {{(POS_W-1){1'b0}}, hdr};
    assign chan_pos_inc = chan_pos + {{(POS_W-1){1'b0}}, 1'b1};
    assign shifted      = {15'd0, data_byte} << bit_count_reg[3:0];
    assign buf_or       = bit_buffer_reg | shifted[17:0];
    assign cnt_sum      = bit_count_reg + 5'd8;
    // channel number completed by this byte: (bytes so far * 8) / 11
    assign bits_done    = {chan_pos_inc, 3'b000};
    assign div_prod     = {9'd0, bits_done} * {{(PROD_W-9){1'b0}}, sfd_pkg::CH_DIV_MUL};
    assign ch_num       = CH_W'(div_prod >> sfd_pkg::CH_DIV_SHIFT);
    assign expected     = POS_W'(DATA_BYTES + 1) + {{(POS_W-1){1'b0}}, hdr}
                          + {{(POS_W-1){1'b0}}, !skip_footer_reg};

    always_comb
    begin
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        pos_next        = pos_reg;
        bad_next        = bad_reg;
        flags_next      = flags_reg;
        store_we        = 1'b0;
        store_addr      = '0;
        cmd_valid       = 1'b0;
        cmd.bad         = 1'b0;
        cmd.flags       = '0;
        cmd.value       = snap;

        if (byte_in)
        begin
            if (pos_reg < POS_W'(POS_SAT))
            begin
                pos_next = pos_reg + {{(POS_W-1){1'b0}}, 1'b1};
                priority if (hdr && pos_reg == '0)
                begin
                    if (data_byte != header_value_reg)
                        bad_next = 1'b1;
                end
                else if (chan_pos < POS_W'(DATA_BYTES))
                begin
                    bit_buffer_next = buf_or;
                    bit_count_next  = cnt_sum;
                    if (cnt_sum >= 5'd11)
                    begin
                        if (ch_num != '0 && ch_num <= CH_W'(NUM_CHANNELS))
                        begin
                            store_we   = 1'b1;
                            store_addr = ADDR_W'(ch_num - {{(CH_W-1){1'b0}}, 1'b1});
                        end
                        bit_buffer_next = buf_or >> sfd_pkg::CH_BITS;
                        bit_count_next  = cnt_sum - 5'd11;
                    end
                end
                else if (chan_pos == POS_W'(DATA_BYTES))
                begin
                    flags_next = data_byte[3:0];
                end
                else if (chan_pos == POS_W'(DATA_BYTES + 1) && !skip_footer_reg)
                begin
                    if (data_byte != footer_value_reg)
                        bad_next = 1'b1;
                end
                else
                begin
                    // past the footer: count the byte only
                end
            end

            if (end_of_frame)
            begin
                cmd_valid = 1'b1;
                cmd.bad   = (pos_next != expected) || bad_next;
                cmd.flags = flags_next;
                // start a fresh frame
                bit_buffer_next = '0;
                bit_count_next  = '0;
                pos_next        = '0;
                bad_next        = 1'b0;
                flags_next      = '0;
            end
        end
    end

    // snapshot the store as it stands after this byte's write
    for (genvar k = 0; k < sfd_pkg::MAX_OUT; k++)
    begin : g_snap
        if (k < OUT_CH)
        begin : g_live
            assign snap[k] = (store_we && store_addr == ADDR_W'(k)) ? buf_or[10:0]
                                                                     : store_reg[k];
        end
        else
        begin : g_none
            assign snap[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            pos_reg        <= '0;
            bad_reg        <= 1'b0;
            flags_reg      <= '0;
        end
        else
        begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
            pos_reg        <= pos_next;
            bad_reg        <= bad_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[store_addr] <= buf_or[10:0];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfd_queue.sv -----
// Two-entry queue of finished frames between the front end and the result sequencer.
// Depends on sfd_pkg for sfd_cmd_t.
`default_nettype none

module sfd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire sfd_pkg::sfd_cmd_t   wr_cmd,
    input  wire logic                rd,
    output logic                     full,
    output logic                     head_valid,
    output sfd_pkg::sfd_cmd_t        head
);

    sfd_pkg::sfd_cmd_t   entry_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_wr      = wr && !full;
    assign do_rd      = rd && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sfd_back.sv -----
// Result sequencer: walks the queued frame one channel per cycle into the output register
// while pop keeps it free. Depends on sfd_pkg for sfd_cmd_t and the status codes.
`default_nettype none

module sfd_back #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire sfd_pkg::sfd_cmd_t   head,
    output logic                     deq,
    input  wire logic                pop,
    output logic                     empty,
    output logic                     status,
    output logic [3:0]               channel_index,
    output logic [10:0]              channel_value,
    output logic                     digital_ch17,
    output logic                     digital_ch18,
    output logic                     signal_lost,
    output logic                     failsafe_active,
    output logic                     last_result
);

    localparam int OUT_CH = (NUM_CHANNELS < sfd_pkg::MAX_OUT) ? NUM_CHANNELS
                                                              : sfd_pkg::MAX_OUT;

    logic         out_valid_reg, out_valid_next;
    logic [3:0]   k_reg, k_next;
    logic         status_reg;
    logic [3:0]   index_reg;
    logic [10:0]  value_reg;
    logic [3:0]   flags_reg;
    logic         last_reg;
    logic         load;
    logic         k_last;

    assign load   = head_valid && (!out_valid_reg || pop);
    assign k_last = (k_reg == 4'(OUT_CH - 1));

    always_comb
    begin
        deq            = 1'b0;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (head.bad || k_last)
            begin
                deq    = 1'b1;
                k_next = '0;
            end
            else
            begin
                k_next = k_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (head.bad)
            begin
                status_reg <= sfd_pkg::STATUS_BAD;
                index_reg  <= '0;
                value_reg  <= '0;
                flags_reg  <= '0;
                last_reg   <= 1'b1;
            end
            else
            begin
                status_reg <= sfd_pkg::STATUS_GOOD;
                index_reg  <= k_reg;
                value_reg  <= head.value[k_reg];
                flags_reg  <= head.flags;
                last_reg   <= k_last;
            end
        end
    end

    assign empty           = !out_valid_reg;
    assign status          = status_reg;
    assign channel_index   = index_reg;
    assign channel_value   = value_reg;
    assign digital_ch17    = flags_reg[0];
    assign digital_ch18    = flags_reg[1];
    assign signal_lost     = flags_reg[2];
    assign failsafe_active = flags_reg[3];
    assign last_result     = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sbus_frame_decoder.sv -----
// Byte-serial decoder of 11-bit servo frames: top level.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
// Usage:
//   Input channel: push one frame byte per transfer (data_byte, end_of_frame set on the
//   last byte). A transfer happens when push is high and full is low. One byte a cycle is
//   taken; full rises only when two decoded frames are waiting for the result side.
//   Result channel: while empty is low the oldest result sits on the result ports; pop
//   takes it. A good frame yields min(NUM_CHANNELS, 16) results in channel order, the
//   last with last_result set; a rejected frame yields one result with status set.
//   With the sequencer idle, the marked byte's frame goes into the queue entry and then
//   its first result into the output register; the rest follow one per cycle while popped.
//   Backpressure: a stalled pop holds the current result. The frame being read out keeps
//   its queue entry until its last result is loaded, so one further frame (two once that
//   last result is loaded) is received before full rises and holds off every byte.
//   Configuration: wr_en, wr_index, wr_data write a register in the same cycle; change
//   registers only while no result is pending.
//   Reset: rst_n clears the frame state, the queue and the output stage and loads the
//   register defaults (header 0x0F, footer 0x00, both bytes expected).
`default_nettype none

module sbus_frame_decoder #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_frame,
    input  wire logic          wr_en,
    input  wire logic [1:0]    wr_index,
    input  wire logic [7:0]    wr_data,
    output logic               empty,
    input  wire logic          pop,
    output logic               status,
    output logic [3:0]         channel_index,
    output logic [10:0]        channel_value,
    output logic               digital_ch17,
    output logic               digital_ch18,
    output logic               signal_lost,
    output logic               failsafe_active,
    output logic               last_result
);

    logic                 byte_in;
    logic                 cmd_valid;
    sfd_pkg::sfd_cmd_t    cmd;
    logic                 q_full;
    logic                 head_valid;
    sfd_pkg::sfd_cmd_t    head;
    logic                 deq;

    assign full    = q_full;
    assign byte_in = push && !q_full;

    sfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_in      (byte_in),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    sfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (cmd_valid),
        .wr_cmd     (cmd),
        .rd         (deq),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    sfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .deq             (deq),
        .pop             (pop),
        .empty           (empty),
        .status          (status),
        .channel_index   (channel_index),
        .channel_value   (channel_value),
        .digital_ch17    (digital_ch17),
        .digital_ch18    (digital_ch18),
        .signal_lost     (signal_lost),
        .failsafe_active (failsafe_active),
        .last_result     (last_result)
    );

endmodule

`default_nettype wire
